// ===== hw/rtl/irfs_pkg.sv =====
// Shared types and constants for the IR frame bit sequencer.
// No dependencies; the control, result-stage, top-level and checker files import this package.
`timescale 1ns / 1ps

package irfs_pkg;

    // default table sizes
    localparam int COMMAND_DEPTH_DEF = 64;
    localparam int DATA_BYTES_DEF    = 16;
    localparam int REPEAT_DEPTH_DEF  = 16;

    // width that holds every count and depth compared in the sequencer
    localparam int CNT_W = 9;

    // wave words are split into an even bank (mark) and an odd bank (space)
    localparam int WAVE_AW = 7;
    localparam int WAVE_DEPTH = 128;

    localparam logic [7:0]  MARKER_CODE = 8'h80;
    localparam logic [15:0] PERIOD_TRIM = 16'h0020;

    // operation codes carried on the input stream
    typedef enum logic [2:0] {
        FN_TICK    = 3'd0,
        FN_WR_CMD  = 3'd1,
        FN_WR_DATA = 3'd2,
        FN_WR_REP  = 3'd3,
        FN_WR_WAVE = 3'd4,
        FN_START   = 3'd5,
        FN_STOP    = 3'd6,
        FN_NOP     = 3'd7
    } func_t;

    // configuration register indexes
    localparam logic [1:0] CFG_COMMAND_COUNT  = 2'd0;
    localparam logic [1:0] CFG_DATA_BIT_COUNT = 2'd1;
    localparam logic [1:0] CFG_REPEAT_COUNT   = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_COMMAND = 2'd1,
        PH_REPEAT  = 2'd2
    } phase_t;

    // code played in the step stage, waiting for its wave words
    typedef struct packed {
        logic valid;
        logic rep;
    } play_t;

    typedef struct packed {
        logic [15:0] mark;
        logic [15:0] period;
        logic        carrier;
        logic        rep;
    } res_t;

endpackage

// ===== hw/rtl/irfs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; used for every table of the sequencer.
`timescale 1ns / 1ps

module irfs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/irfs_ctrl.sv =====
// Sequencer control: input acceptance, table write/read addressing, frame state
// and the step stage that picks the played code. Depends on irfs_pkg.
`timescale 1ns / 1ps

module irfs_ctrl import irfs_pkg::*; #(
    parameter int COMMAND_DEPTH = COMMAND_DEPTH_DEF,
    parameter int DATA_BYTES    = DATA_BYTES_DEF,
    parameter int REPEAT_DEPTH  = REPEAT_DEPTH_DEF,
    parameter int CMD_AW  = (COMMAND_DEPTH > 1) ? $clog2(COMMAND_DEPTH) : 1,
    parameter int DATA_AW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1,
    parameter int REP_AW  = (REPEAT_DEPTH > 1) ? $clog2(REPEAT_DEPTH) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  func_t              func,
    input  logic [7:0]         entry_index,
    // configuration writes
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    // result buffer fill
    input  logic [1:0]         occ,
    // table ports
    output logic               cmd_we,
    output logic [CMD_AW-1:0]  cmd_waddr,
    output logic [CMD_AW-1:0]  cmd_raddr,
    input  logic [7:0]         cmd_rd_data,
    output logic               data_we,
    output logic [DATA_AW-1:0] data_waddr,
    output logic [DATA_AW-1:0] data_raddr,
    input  logic [7:0]         data_rd_data,
    output logic               rep_we,
    output logic [REP_AW-1:0]  rep_waddr,
    output logic [REP_AW-1:0]  rep_raddr,
    input  logic [7:0]         rep_rd_data,
    output logic               wave_even_we,
    output logic               wave_odd_we,
    output logic [WAVE_AW-1:0] wave_waddr,
    output logic [WAVE_AW-1:0] wave_raddr,
    // played code toward the result stage
    output play_t              play
);

    localparam int CPOS_W = $clog2(COMMAND_DEPTH + 1);

    phase_t              phase_reg, phase_next;
    logic [CPOS_W-1:0]   cpos_reg, cpos_next;
    logic [7:0]          bpos_reg, bpos_next;
    logic [REP_AW-1:0]   rpos_reg, rpos_next;
    logic                stop_reg, stop_next;
    logic                s1_valid_reg;
    play_t               play_reg, play_next;

    logic [6:0]          command_count_reg;
    logic [7:0]          data_bit_count_reg;
    logic [4:0]          repeat_count_reg;

    logic                acc;
    logic                is_play;
    logic                play_ok;
    logic [2:0]          pend;
    logic                start_acc;

    logic                cmd_live;
    logic                marker_bit;
    logic                byte_ok;
    logic                data_bit;
    logic                rep_end;
    logic [CNT_W-1:0]    rp1;
    logic [REP_AW-1:0]   rpos_adv;
    logic                emit;
    logic                emit_rep;
    logic [7:0]          code;

    // acceptance: a play op waits for the step stage and for result space
    assign is_play   = (func == FN_TICK) || (func == FN_START);
    assign pend      = 3'(occ) + 3'(s1_valid_reg) + 3'(play_reg.valid);
    assign play_ok   = !s1_valid_reg && (pend <= 3'd1);
    assign s_tready  = !is_play || play_ok;
    assign acc       = s_tvalid && s_tready;
    assign start_acc = acc && (func == FN_START);

    // table writes, out-of-range indexes dropped
    assign cmd_we     = acc && (func == FN_WR_CMD)
                        && (CNT_W'(entry_index) < CNT_W'(COMMAND_DEPTH));
    assign cmd_waddr  = entry_index[CMD_AW-1:0];
    assign data_we    = acc && (func == FN_WR_DATA)
                        && (CNT_W'(entry_index) < CNT_W'(DATA_BYTES));
    assign data_waddr = entry_index[DATA_AW-1:0];
    assign rep_we     = acc && (func == FN_WR_REP)
                        && (CNT_W'(entry_index) < CNT_W'(REPEAT_DEPTH));
    assign rep_waddr  = entry_index[REP_AW-1:0];
    assign wave_even_we = acc && (func == FN_WR_WAVE) && !entry_index[0];
    assign wave_odd_we  = acc && (func == FN_WR_WAVE) && entry_index[0];
    assign wave_waddr   = entry_index[7:1];

    // table reads at the current positions, zero on start
    assign cmd_raddr  = start_acc ? '0 : cpos_reg[CMD_AW-1:0];
    assign data_raddr = start_acc ? '0 : bpos_reg[3 +: DATA_AW];
    assign rep_raddr  = start_acc ? '0 : rpos_reg;

    // step-stage decode
    assign cmd_live   = (CNT_W'(cpos_reg) < CNT_W'(command_count_reg))
                        && (CNT_W'(cpos_reg) < CNT_W'(COMMAND_DEPTH));
    assign marker_bit = (cmd_rd_data == MARKER_CODE) && (bpos_reg < data_bit_count_reg);
    assign byte_ok    = CNT_W'(bpos_reg[7:3]) < CNT_W'(DATA_BYTES);
    assign data_bit   = byte_ok && data_rd_data[bpos_reg[2:0]];
    assign rep_end    = (rpos_reg == '0) && stop_reg;
    assign rp1        = CNT_W'(rpos_reg) + CNT_W'(1);
    assign rpos_adv   = ((rp1 >= CNT_W'(repeat_count_reg)) || (rp1 >= CNT_W'(REPEAT_DEPTH)))
                        ? '0 : rp1[REP_AW-1:0];

    // next state of the frame
    always_comb
    begin
        phase_next = phase_reg;
        cpos_next  = cpos_reg;
        bpos_next  = bpos_reg;
        rpos_next  = rpos_reg;
        stop_next  = stop_reg;
        if (s1_valid_reg)
        begin
            case (phase_reg)
                PH_COMMAND:
                begin
                    if (cmd_live)
                    begin
                        if (marker_bit)
                        begin
                            bpos_next = bpos_reg + 8'd1;
                            if ((bpos_reg + 8'd1) == data_bit_count_reg)
                            begin
                                cpos_next = cpos_reg + CPOS_W'(1);
                            end
                        end
                        else
                        begin
                            cpos_next = cpos_reg + CPOS_W'(1);
                        end
                    end
                    else if (stop_reg)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_REPEAT;
                        rpos_next  = rpos_adv;
                    end
                end
                PH_REPEAT:
                begin
                    if (rep_end)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        rpos_next = rpos_adv;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        // start and stop transfers
        if (start_acc)
        begin
            phase_next = PH_COMMAND;
            cpos_next  = '0;
            bpos_next  = '0;
            rpos_next  = '0;
            stop_next  = 1'b0;
        end
        else if (acc && (func == FN_STOP))
        begin
            stop_next = 1'b1;
        end
    end

    // played code of the step stage
    always_comb
    begin
        emit     = 1'b0;
        emit_rep = 1'b0;
        code     = cmd_rd_data;
        case (phase_reg)
            PH_COMMAND:
            begin
                if (cmd_live)
                begin
                    emit = 1'b1;
                    code = marker_bit ? {7'd0, data_bit} : cmd_rd_data;
                end
                else if (!stop_reg)
                begin
                    emit     = 1'b1;
                    emit_rep = 1'b1;
                    code     = rep_rd_data;
                end
            end
            PH_REPEAT:
            begin
                emit     = !rep_end;
                emit_rep = 1'b1;
                code     = rep_rd_data;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign play_next.valid = s1_valid_reg && emit;
    assign play_next.rep   = emit_rep;
    assign wave_raddr      = code[WAVE_AW-1:0];
    assign play            = play_reg;

    // frame state, stage valids and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            cpos_reg           <= '0;
            bpos_reg           <= '0;
            rpos_reg           <= '0;
            stop_reg           <= 1'b0;
            s1_valid_reg       <= 1'b0;
            play_reg           <= '0;
            command_count_reg  <= 7'd0;
            data_bit_count_reg <= 8'd0;
            repeat_count_reg   <= 5'd1;
        end
        else
        begin
            phase_reg    <= phase_next;
            cpos_reg     <= cpos_next;
            bpos_reg     <= bpos_next;
            rpos_reg     <= rpos_next;
            stop_reg     <= stop_next;
            s1_valid_reg <= acc && is_play;
            play_reg     <= play_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_COMMAND_COUNT:  command_count_reg  <= cfg_data[6:0];
                    CFG_DATA_BIT_COUNT: data_bit_count_reg <= cfg_data;
                    CFG_REPEAT_COUNT:   repeat_count_reg   <= cfg_data[4:0];
                    default:            repeat_count_reg   <= repeat_count_reg;
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/irfs_res_fifo.sv =====
// Result stage: forms mark, period and carrier flag from the wave words and
// holds results in a two-entry buffer toward the output stream. Depends on irfs_pkg.
`timescale 1ns / 1ps

module irfs_res_fifo import irfs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  play_t       play,
    input  logic [15:0] mark_rd,
    input  logic [15:0] space_rd,
    input  logic        m_tready,
    output logic        m_tvalid,
    output res_t        res,
    output logic [1:0]  occ
);

    res_t       ent_reg [2];
    res_t       new_res;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    // result formed from the two wave words
    assign new_res.mark    = mark_rd;
    assign new_res.period  = mark_rd + space_rd - PERIOD_TRIM;
    assign new_res.carrier = |mark_rd;
    assign new_res.rep     = play.rep;

    assign push     = play.valid;
    assign pop      = (count_reg != 2'd0) && m_tready;
    assign m_tvalid = count_reg != 2'd0;
    assign res      = ent_reg[rd_ptr_reg];
    assign occ      = count_reg;

    // fill level
    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    // buffer entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= new_res;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/ir_frame_bit_sequencer.sv =====
// IR frame bit sequencer, top level: table RAMs, control and result stage.
// Depends on irfs_pkg, irfs_ram, irfs_ctrl and irfs_res_fifo.
//
// Usage: the s_ stream carries operations (s_tuser) with a table index and a
// value (s_tdata). Write operations load the command, data byte, repeat and
// wave tables; start begins a frame and plays its first code, each tick plays
// the next one, stop ends the frame at the next repeat pass. Each played code
// gives one m_ transfer: mark length, period and carrier flag in m_tdata and
// the repeat flag in m_tuser. Writes are taken every cycle; a tick or start
// waits while another is in the step stage; its result passes the table read,
// step stage and wave word read. Results wait in a two-entry buffer; when the
// receiver stalls, ticks are held off once it is full while writes and stop
// keep flowing. The cfg channel is always ready; the user must write it only
// while the block is idle, which the block does not enforce. Reset idles the
// frame, clears positions and the pending stop and sets the counts to their
// defaults; table contents are undefined until written and need no clearing.
`timescale 1ns / 1ps

module ir_frame_bit_sequencer import irfs_pkg::*; #(
    parameter int COMMAND_DEPTH = COMMAND_DEPTH_DEF,
    parameter int DATA_BYTES    = DATA_BYTES_DEF,
    parameter int REPEAT_DEPTH  = REPEAT_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // entry_index[7:0], entry_value[23:8]
    input  logic [2:0]  s_tuser,    // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // mark_length[15:0], period_length[31:16],
                                    // carrier_on[32], zero[39:33]
    output logic        m_tuser,    // in_repeat[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int CMD_AW  = (COMMAND_DEPTH > 1) ? $clog2(COMMAND_DEPTH) : 1;
    localparam int DATA_AW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam int REP_AW  = (REPEAT_DEPTH > 1) ? $clog2(REPEAT_DEPTH) : 1;

    logic               cmd_we, data_we, rep_we, wave_even_we, wave_odd_we;
    logic [CMD_AW-1:0]  cmd_waddr, cmd_raddr;
    logic [DATA_AW-1:0] data_waddr, data_raddr;
    logic [REP_AW-1:0]  rep_waddr, rep_raddr;
    logic [WAVE_AW-1:0] wave_waddr, wave_raddr;
    logic [7:0]         cmd_rd_data, data_rd_data, rep_rd_data;
    logic [15:0]        mark_rd, space_rd;
    logic [1:0]         occ;
    play_t              play;
    res_t               res;

    assign cfg_ready = 1'b1;

    irfs_ctrl #(
        .COMMAND_DEPTH (COMMAND_DEPTH),
        .DATA_BYTES    (DATA_BYTES),
        .REPEAT_DEPTH  (REPEAT_DEPTH),
        .CMD_AW        (CMD_AW),
        .DATA_AW       (DATA_AW),
        .REP_AW        (REP_AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .func         (func_t'(s_tuser)),
        .entry_index  (s_tdata[7:0]),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .occ          (occ),
        .cmd_we       (cmd_we),
        .cmd_waddr    (cmd_waddr),
        .cmd_raddr    (cmd_raddr),
        .cmd_rd_data  (cmd_rd_data),
        .data_we      (data_we),
        .data_waddr   (data_waddr),
        .data_raddr   (data_raddr),
        .data_rd_data (data_rd_data),
        .rep_we       (rep_we),
        .rep_waddr    (rep_waddr),
        .rep_raddr    (rep_raddr),
        .rep_rd_data  (rep_rd_data),
        .wave_even_we (wave_even_we),
        .wave_odd_we  (wave_odd_we),
        .wave_waddr   (wave_waddr),
        .wave_raddr   (wave_raddr),
        .play         (play)
    );

    // command codes
    irfs_ram #(.WIDTH(8), .DEPTH(COMMAND_DEPTH), .ADDR_W(CMD_AW)) u_cmd_ram (
        .clk     (clk),
        .wr_en   (cmd_we),
        .wr_addr (cmd_waddr),
        .wr_data (s_tdata[15:8]),
        .rd_addr (cmd_raddr),
        .rd_data (cmd_rd_data)
    );

    // payload bytes
    irfs_ram #(.WIDTH(8), .DEPTH(DATA_BYTES), .ADDR_W(DATA_AW)) u_data_ram (
        .clk     (clk),
        .wr_en   (data_we),
        .wr_addr (data_waddr),
        .wr_data (s_tdata[15:8]),
        .rd_addr (data_raddr),
        .rd_data (data_rd_data)
    );

    // repeat codes
    irfs_ram #(.WIDTH(8), .DEPTH(REPEAT_DEPTH), .ADDR_W(REP_AW)) u_rep_ram (
        .clk     (clk),
        .wr_en   (rep_we),
        .wr_addr (rep_waddr),
        .wr_data (s_tdata[15:8]),
        .rd_addr (rep_raddr),
        .rd_data (rep_rd_data)
    );

    // wave words at even addresses hold marks
    irfs_ram #(.WIDTH(16), .DEPTH(WAVE_DEPTH), .ADDR_W(WAVE_AW)) u_mark_ram (
        .clk     (clk),
        .wr_en   (wave_even_we),
        .wr_addr (wave_waddr),
        .wr_data (s_tdata[23:8]),
        .rd_addr (wave_raddr),
        .rd_data (mark_rd)
    );

    // wave words at odd addresses hold spaces
    irfs_ram #(.WIDTH(16), .DEPTH(WAVE_DEPTH), .ADDR_W(WAVE_AW)) u_space_ram (
        .clk     (clk),
        .wr_en   (wave_odd_we),
        .wr_addr (wave_waddr),
        .wr_data (s_tdata[23:8]),
        .rd_addr (wave_raddr),
        .rd_data (space_rd)
    );

    irfs_res_fifo u_res (
        .clk      (clk),
        .rst_n    (rst_n),
        .play     (play),
        .mark_rd  (mark_rd),
        .space_rd (space_rd),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res      (res),
        .occ      (occ)
    );

    // output packing
    assign m_tdata = {7'd0, res.carrier, res.period, res.mark};
    assign m_tuser = res.rep;

endmodule

// ===== hw/rtl/irfs_checker.sv =====
// Port-level checks for the IR frame bit sequencer, bound to the top level.
// Depends on irfs_pkg and ir_frame_bit_sequencer.
`timescale 1ns / 1ps

module irfs_port_checker import irfs_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);

    logic play_acc;

    assign play_acc = s_tvalid && s_tready
                      && ((s_tuser == FN_TICK) || (s_tuser == FN_START));

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // carrier flag follows the mark length
    a_carrier: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[32] == (m_tdata[15:0] != 16'd0)))
        else $error("carrier flag disagrees with mark length");

    // plays are never accepted back to back
    a_play_gap: assert property (@(posedge clk) disable iff (!rst_n)
        play_acc |=> !play_acc)
        else $error("plays accepted back to back");

    // a result that raises m_tvalid traces back to an accepted play
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(play_acc, 3))
        else $error("result without a preceding play");

endmodule

bind ir_frame_bit_sequencer irfs_port_checker u_irfs_checker (.*);
